// ===== rtl/insertion_sorter_core_macros.svh =====
// Assertion macros shared by the sorter's checker.
`ifndef INSERTION_SORTER_CORE_MACROS_SVH
`define INSERTION_SORTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define ISORT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ISORT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/isort_pkg.sv =====
// Shared types and constants of the insertion sorter.
`default_nettype none
package isort_pkg;

  localparam int KEY_W        = 32;
  localparam int CAPACITY_DEF = 16;

  typedef logic signed [KEY_W-1:0] key_t;

  // Per-cycle command broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;    // insert the incoming key
    logic shift;  // move every cell down by one place
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/insertion_sorter_core.sv =====
// Insertion sorter: chain of compare-and-shift cells with a drain path.
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_stall  | in_key_value, in_set_end
//   out     | output    | out_valid/out_stall| out_sorted_value, out_run_last, out_dropped
//
// An input word is inserted in a single step: every cell compares and shifts at once.
// A word with in_set_end closes the set; the chain then shifts down one place per
// cycle into the output register while out_stall does not hold a waiting result.
// in_stall is high while draining. Reset (synchronous, rst_n low) empties the chain
// and the output register.
`default_nettype none
module insertion_sorter_core #(
  parameter int CAPACITY = isort_pkg::CAPACITY_DEF
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     in_valid,
  output logic                    in_stall,
  input  isort_pkg::key_t         in_key_value,
  input  wire                     in_set_end,
  output logic                    out_valid,
  input  wire                     out_stall,
  output isort_pkg::key_t         out_sorted_value,
  output logic                    out_run_last,
  output logic                    out_dropped
);
  import isort_pkg::*;

  key_t       cell_key   [CAPACITY];
  logic       cell_valid [CAPACITY];
  logic       cell_take  [CAPACITY];
  cell_ctrl_t ctrl;

  logic drain_r, drain_nxt;
  logic ovf_r, ovf_nxt;
  logic out_valid_r, out_valid_nxt;
  key_t out_value_r, out_value_nxt;
  logic out_last_r, out_last_nxt;
  logic out_drop_r, out_drop_nxt;

  logic in_fire, full, out_load, last_key;

  assign full     = cell_valid[CAPACITY-1];
  assign in_fire  = in_valid && !drain_r;
  assign out_load = drain_r && (!out_valid_r || !out_stall);
  assign last_key = !cell_valid[1];

  assign ctrl.ins   = in_fire && !full;
  assign ctrl.shift = out_load;

  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      key_t lo_key, hi_key;
      logic lo_valid, lo_take, hi_valid;
      if (gi == 0) begin : g_lo_edge
        assign lo_key   = in_key_value;
        assign lo_valid = 1'b1;
        assign lo_take  = 1'b0;
      end else begin : g_lo
        assign lo_key   = cell_key[gi-1];
        assign lo_valid = cell_valid[gi-1];
        assign lo_take  = cell_take[gi-1];
      end
      if (gi == CAPACITY-1) begin : g_hi_edge
        assign hi_key   = cell_key[gi];
        assign hi_valid = 1'b0;
      end else begin : g_hi
        assign hi_key   = cell_key[gi+1];
        assign hi_valid = cell_valid[gi+1];
      end
      isort_cell u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (ctrl),
        .ins_key  (in_key_value),
        .lo_key   (lo_key),
        .lo_valid (lo_valid),
        .lo_take  (lo_take),
        .hi_key   (hi_key),
        .hi_valid (hi_valid),
        .key_o    (cell_key[gi]),
        .valid_o  (cell_valid[gi]),
        .take_o   (cell_take[gi])
      );
    end
  endgenerate

  always_comb begin
    drain_nxt     = drain_r;
    ovf_nxt       = ovf_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_drop_nxt  = out_drop_r;
    if (in_fire) begin
      if (full) begin
        ovf_nxt = 1'b1;
      end
      drain_nxt = in_set_end;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = cell_key[0];
      out_last_nxt  = last_key;
      out_drop_nxt  = ovf_r;
      // end of set: release input side and clear the drop flag
      if (last_key) begin
        drain_nxt = 1'b0;
        ovf_nxt   = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      drain_r     <= 1'b0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      drain_r     <= drain_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_drop_r  <= out_drop_nxt;
  end

  assign in_stall         = drain_r;
  assign out_valid        = out_valid_r;
  assign out_sorted_value = out_value_r;
  assign out_run_last     = out_last_r;
  assign out_dropped      = out_drop_r;

endmodule
`default_nettype wire

// ===== rtl/isort_cell.sv =====
// One place of the sorted chain: holds a key and its valid bit.
`default_nettype none
module isort_cell (
  input  wire                     clk,
  input  wire                     rst_n,
  input  isort_pkg::cell_ctrl_t   ctrl,
  input  isort_pkg::key_t         ins_key,
  input  isort_pkg::key_t         lo_key,
  input  wire                     lo_valid,
  input  wire                     lo_take,
  input  isort_pkg::key_t         hi_key,
  input  wire                     hi_valid,
  output isort_pkg::key_t         key_o,
  output logic                    valid_o,
  output logic                    take_o
);
  import isort_pkg::*;

  key_t key_r, key_nxt;
  logic valid_r, valid_nxt;

  // At or above the insertion point: empty, or strictly greater (keeps ties stable).
  assign take_o  = !valid_r || (key_r > ins_key);
  assign key_o   = key_r;
  assign valid_o = valid_r;

  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    if (ctrl.shift) begin
      key_nxt   = hi_key;
      valid_nxt = hi_valid;
    end else if (ctrl.ins && take_o) begin
      // take the lower neighbor's key if it moves up, else the new key
      key_nxt   = lo_take ? lo_key : ins_key;
      valid_nxt = lo_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    key_r <= key_nxt;
  end

endmodule
`default_nettype wire

// ===== rtl/isort_checker.sv =====
// Port-level checks of the insertion sorter and their bind.
`default_nettype none
`include "insertion_sorter_core_macros.svh"
module isort_checker (
  input wire                clk,
  input wire                rst_n,
  input wire                in_valid,
  input wire                in_stall,
  input isort_pkg::key_t    in_key_value,
  input wire                in_set_end,
  input wire                out_valid,
  input wire                out_stall,
  input isort_pkg::key_t    out_sorted_value,
  input wire                out_run_last,
  input wire                out_dropped
);
  logic in_seen;
  assign in_seen = in_valid && (in_key_value == in_key_value);

  // a closing word starts the drain, so input must stall next
  `ISORT_ASSERT_NEXT(a_close_stalls, in_seen && !in_stall && in_set_end, in_stall, "no stall after set end")
  // no input word may slip in between results of one set
  `ISORT_ASSERT_NOW(a_set_blocks_in, out_valid && !out_run_last, in_stall, "input open mid-set")
  // a non-final result taken is followed by the next one at once
  `ISORT_ASSERT_NEXT(a_drain_gapless, out_valid && !out_stall && !out_run_last, out_valid, "gap in drained set")
  // the drop flag is the same on every result of a set
  `ISORT_ASSERT_NEXT(a_drop_steady, out_valid && !out_stall && !out_run_last, out_dropped == $past(out_dropped), "drop flag changed in set")
  // stalled result holds
  `ISORT_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_sorted_value), "stalled result changed")

endmodule

bind insertion_sorter_core isort_checker u_isort_checker (.*);
`default_nettype wire
